FILE: src/dpts_pkg.sv
// Shared types, constants and a helper function of the depth pixel statistics block.
`timescale 1ns / 1ps
package dpts_pkg;

  localparam int PIXELS_DEFAULT = 65536;
  localparam int INDEX_MAX_DEPTH = 65536;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_AVG_CYCLE = 3'd1;
  localparam logic [2:0] REG_SNAP_CYCLE = 3'd2;
  localparam logic [2:0] REG_SAT_CODE = 3'd3;
  localparam logic [2:0] REG_INV_CODE = 3'd4;

  localparam logic MODE_AVERAGE = 1'b0;
  localparam logic MODE_SNAPSHOT = 1'b1;

  localparam logic [63:0] RECIP10 = 64'h0000_0000_CCCC_CCCD;
  localparam logic [61:0] SCALE_SQ = 62'd10000;

  typedef struct packed {
    logic [23:0] sum;
    logic [7:0]  valid_count;
    logic [7:0]  sat_count;
    logic [39:0] square_sum;
  } pix_entry_t;

  localparam int ENTRY_W = $bits(pix_entry_t);

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  // Exact x / 10 for any 32-bit x.
  function automatic logic [31:0] div10(input logic [31:0] x);
    logic [63:0] p;
    p = {32'b0, x} * RECIP10;
    return 32'(p >> 35);
  endfunction

endpackage

FILE: src/dpts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module dpts_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/dpts_div.sv
// Bit-serial restoring divider: 32-bit dividend by a nonzero 8-bit divisor.
`timescale 1ns / 1ps
module dpts_div (
  input  logic                clk,
  input  logic                rst,
  input  dpts_pkg::div_req_t  req,
  output logic                busy,
  output logic [31:0]         quotient
);
  import dpts_pkg::*;

  logic [7:0] rem;
  logic [7:0] divisor;
  logic [5:0] cnt;
  logic [8:0] shifted;
  logic       fits;

  assign shifted = {rem, quotient[31]};
  assign fits = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      divisor <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      quotient <= {quotient[30:0], fits};
      rem <= fits ? 8'(shifted - {1'b0, divisor}) : shifted[7:0];
    end
  end

endmodule

FILE: src/dpts_sqrt.sv
// Digit-by-digit integer square root of a 62-bit value, one result bit per cycle.
`timescale 1ns / 1ps
module dpts_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [61:0] radicand,
  output logic        busy,
  output logic [30:0] root
);
  import dpts_pkg::*;

  logic [61:0] rad_sh;
  logic [32:0] rem;
  logic [4:0]  cnt;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        fits;

  assign rem_sh = {rem, rad_sh[61:60]};
  assign trial = {2'b00, root, 2'b01};
  assign fits = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'd31;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= radicand;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[59:0], 2'b00};
      rem <= fits ? 33'(rem_sh - trial) : rem_sh[32:0];
      root <= {root[29:0], fits};
    end
  end

endmodule

FILE: src/depth_pixel_temporal_stats.sv
// Top level: per-pixel temporal mean and standard deviation of a depth stream.
`timescale 1ns / 1ps
// The per-pixel sums, counts and sums of squares live in one RAM word per pixel and
// are updated by read-modify-write, one request at a time. An emitting request in
// averaging mode waits on the bit-serial 32-step divider. An emitting request in
// snapshot mode runs the 31-step square root beside the mean division, then a
// second 32-step division scales the root. After reset and after every write to
// the mode register the block runs a clearing pass over all min(PIXELS, 65536)
// RAM words, during which it stalls input requests.
module depth_pixel_temporal_stats #(
  parameter int PIXELS = dpts_pkg::PIXELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] pixel_index,
  input  logic [15:0] depth,
  input  logic        last_pixel,
  input  logic        last_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_index,
  output logic [15:0] shown_depth,
  output logic [15:0] mean_depth,
  output logic [15:0] std_tenths
);
  import dpts_pkg::*;

  localparam int MEM_DEPTH = (PIXELS > INDEX_MAX_DEPTH) ? INDEX_MAX_DEPTH : PIXELS;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_DIVM  = 4'd3;
  localparam logic [3:0] ST_PROD  = 4'd4;
  localparam logic [3:0] ST_DIFF  = 4'd5;
  localparam logic [3:0] ST_SCALE = 4'd6;
  localparam logic [3:0] ST_WAIT  = 4'd7;
  localparam logic [3:0] ST_DIVS  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0]  state;
  logic        mode;
  logic [7:0]  avg_cycle;
  logic [7:0]  snap_cycle;
  logic [15:0] sat_code;
  logic [15:0] inv_code;
  logic [7:0]  frame_count;
  logic [AW-1:0] clr_addr;

  logic [15:0] req_index;
  logic [15:0] req_depth;
  logic [31:0] sq_sample;
  logic        emit;

  logic [23:0] w_sum;
  logic [7:0]  w_cnt;
  logic [39:0] w_sqs;
  logic [47:0] nq;
  logic [47:0] s2;
  logic [47:0] diff;
  logic [31:0] mean_q;
  logic [15:0] res_shown;
  logic [15:0] res_mean;
  logic [15:0] res_std;

  logic        accept;
  logic        in_range;
  logic        reaching;
  logic        is_sat;
  logic        is_valid;
  logic        mode_write;
  pix_entry_t  rd_entry;
  pix_entry_t  upd;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic        ram_we;
  div_req_t    div_req;
  logic        div_busy;
  logic [31:0] div_quot;
  logic        sqrt_start;
  logic        sqrt_busy;
  logic [30:0] sqrt_root;
  logic        out_load;
  logic [31:0] std_q;

  assign in_stall = state != ST_IDLE;
  assign accept = in_valid && !in_stall;
  assign in_range = 32'(pixel_index) < 32'(PIXELS);
  assign reaching = ({1'b0, frame_count} + 9'd1) >= {1'b0, avg_cycle};
  assign mode_write = cfg_we && cfg_index == REG_MODE;
  assign is_sat = req_depth == sat_code;
  assign is_valid = !is_sat && req_depth != inv_code;
  assign rd_entry = pix_entry_t'(ram_rdata);

  always_comb begin
    upd = rd_entry;
    if (mode == MODE_SNAPSHOT && is_sat) begin
      if (rd_entry.sat_count != 8'hFF) begin
        upd.sat_count = rd_entry.sat_count + 8'd1;
      end
    end else if (is_valid && rd_entry.valid_count != 8'hFF) begin
      upd.sum = rd_entry.sum + 24'(req_depth);
      upd.valid_count = rd_entry.valid_count + 8'd1;
      if (mode == MODE_SNAPSHOT) begin
        upd.square_sum = rd_entry.square_sum + 40'(sq_sample);
      end
    end
  end

  assign ram_we = state == ST_CLEAR || state == ST_READ;
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : req_index[AW-1:0];
  assign ram_wdata = (state == ST_CLEAR || emit) ? '0 : ENTRY_W'(upd);

  dpts_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pixel_index[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    div_req.start = 1'b0;
    div_req.dividend = 32'(upd.sum);
    div_req.divisor = upd.valid_count;
    if (state == ST_READ && emit && upd.valid_count != 8'd0) begin
      div_req.start = 1'b1;
      if (mode == MODE_SNAPSHOT) begin
        div_req.dividend = 32'(upd.sum) * 32'd10;
      end
    end else if (state == ST_WAIT && !div_busy && !sqrt_busy) begin
      div_req.start = 1'b1;
      div_req.dividend = 32'(sqrt_root);
      div_req.divisor = w_cnt;
    end
  end

  dpts_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .busy(div_busy),
    .quotient(div_quot)
  );

  assign sqrt_start = state == ST_SCALE;

  dpts_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .start(sqrt_start),
    .radicand(62'(diff) * SCALE_SQ),
    .busy(sqrt_busy),
    .root(sqrt_root)
  );

  assign out_load = state == ST_OUT && (!out_valid || !out_stall);
  assign std_q = div10(div_quot + 32'd5);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_AVERAGE;
      avg_cycle <= 8'd1;
      snap_cycle <= 8'd1;
      sat_code <= 16'hFFFF;
      inv_code <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       mode <= cfg_data[0];
        REG_AVG_CYCLE:  avg_cycle <= cfg_data[7:0];
        REG_SNAP_CYCLE: snap_cycle <= cfg_data[7:0];
        REG_SAT_CODE:   sat_code <= cfg_data;
        REG_INV_CODE:   inv_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      frame_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (mode_write) begin
        state <= ST_CLEAR;
        clr_addr <= '0;
        frame_count <= '0;
      end else begin
        unique case (state)
          ST_CLEAR: begin
            clr_addr <= clr_addr + AW'(1);
            if (32'(clr_addr) == 32'(MEM_DEPTH - 1)) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (accept) begin
              if (mode == MODE_AVERAGE && last_pixel) begin
                frame_count <= reaching ? 8'd0 : frame_count + 8'd1;
              end
              if (in_range) begin
                state <= ST_READ;
              end
            end
          end
          ST_READ: begin
            if (!emit) begin
              state <= ST_IDLE;
            end else if (upd.valid_count == 8'd0) begin
              state <= ST_OUT;
            end else if (mode == MODE_AVERAGE) begin
              state <= ST_DIVM;
            end else begin
              state <= ST_PROD;
            end
          end
          ST_DIVM: if (!div_busy) state <= ST_OUT;
          ST_PROD: state <= ST_DIFF;
          ST_DIFF: state <= ST_SCALE;
          ST_SCALE: state <= ST_WAIT;
          ST_WAIT: if (!div_busy && !sqrt_busy) state <= ST_DIVS;
          ST_DIVS: if (!div_busy) state <= ST_FIN;
          ST_FIN: state <= ST_OUT;
          ST_OUT: if (out_load) state <= ST_IDLE;
          default: state <= ST_CLEAR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_index <= pixel_index;
      req_depth <= depth;
      sq_sample <= 32'(depth) * 32'(depth);
      emit <= in_range && ((mode == MODE_AVERAGE) ? reaching : last_frame);
    end
    if (state == ST_READ) begin
      w_sum <= upd.sum;
      w_cnt <= upd.valid_count;
      w_sqs <= upd.square_sum;
      res_std <= '0;
      res_mean <= inv_code;
      if (mode == MODE_SNAPSHOT && upd.sat_count > (snap_cycle >> 1)) begin
        res_shown <= sat_code;
      end else begin
        res_shown <= inv_code;
      end
    end
    if (state == ST_DIVM && !div_busy) begin
      res_shown <= div_quot[15:0];
      res_mean <= div_quot[15:0];
    end
    if (state == ST_PROD) begin
      nq <= 48'(w_cnt) * 48'(w_sqs);
      s2 <= 48'(w_sum) * 48'(w_sum);
    end
    if (state == ST_DIFF) begin
      diff <= (nq > s2) ? nq - s2 : '0;
    end
    if (state == ST_WAIT && !div_busy && !sqrt_busy) begin
      mean_q <= div_quot;
    end
    if (state == ST_FIN) begin
      res_mean <= 16'(div10(mean_q + 32'd5));
      res_shown <= 16'(div10(mean_q + 32'd5));
      res_std <= (std_q > 32'd65535) ? 16'hFFFF : std_q[15:0];
    end
    if (out_load) begin
      out_index <= req_index;
      shown_depth <= res_shown;
      mean_depth <= res_mean;
      std_tenths <= res_std;
    end
  end

  a_read_follows_accept: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> $past(accept))
    else $error("RAM read data used without a preceding accepted request");

  a_ram_write_owner: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_READ))
    else $error("RAM written outside the clear pass or the update cycle");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_start_idle: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> !sqrt_busy)
    else $error("square root started while busy");

endmodule
